/* design/rotary_encoder_step_decoder_defines.svh */
// ----------------------------------------------------------------------------
// rotary encoder step decoder assertion macros
// shared concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ROTARY_ENCODER_STEP_DECODER_DEFINES_SVH
`define ROTARY_ENCODER_STEP_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define RESD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RESD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RESD_ASSERT_IMP(lbl, ante, cons)
`define RESD_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* design/resd_pkg.sv */
// ----------------------------------------------------------------------------
// rotary encoder step decoder package
// shared types and constants
// ----------------------------------------------------------------------------
package resd_pkg;

    localparam int CH_W   = 2;
    localparam int CNT_W  = 8;
    localparam int POS_W  = 2;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_SKIP_LEFT  = 2'd0;
    localparam logic [IDX_W-1:0] REG_SKIP_RIGHT = 2'd1;

    localparam logic [POS_W-1:0] DELTA_RIGHT = 2'd1;
    localparam logic [POS_W-1:0] DELTA_LEFT  = 2'd3;

    // per-channel state word held in the state ram
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] left_cnt;
        logic [CNT_W-1:0] right_cnt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // outcome of one state update
    typedef struct packed {
        logic   wr;
        logic   fire;
        logic   right;
        entry_t entry;
    } step_t;

endpackage

/* design/resd_in_if.sv */
// ----------------------------------------------------------------------------
// encoder sample channel
// valid/ready channel carrying one pin sample of one encoder
// ----------------------------------------------------------------------------
interface resd_in_if;
    logic                       valid;
    logic                       ready;
    logic [resd_pkg::CH_W-1:0]  channel;
    logic                       clk_level;
    logic                       dt_level;

    modport source (output valid, output channel, output clk_level, output dt_level,
                    input ready);
    modport sink   (input valid, input channel, input clk_level, input dt_level,
                    output ready);
endinterface

/* design/resd_out_if.sv */
// ----------------------------------------------------------------------------
// encoder action channel
// valid/ready channel carrying one fired encoder action
// ----------------------------------------------------------------------------
interface resd_out_if;
    logic                       valid;
    logic                       ready;
    logic [resd_pkg::CH_W-1:0]  event_channel;
    logic                       turn_right;

    modport source (output valid, output event_channel, output turn_right,
                    input ready);
    modport sink   (input valid, input event_channel, input turn_right,
                    output ready);
endinterface

/* design/resd_ram.sv */
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module resd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/resd_step.sv */
// ----------------------------------------------------------------------------
// encoder state update
// decodes the position change and advances the skip counters of one channel
// ----------------------------------------------------------------------------
module resd_step (
    input  logic                           in_range,
    input  logic [resd_pkg::POS_W-1:0]     pos,
    input  resd_pkg::entry_t               cur,
    input  logic [resd_pkg::CNT_W-1:0]     lim_left,
    input  logic [resd_pkg::CNT_W-1:0]     lim_right,
    output resd_pkg::step_t                step
);

    logic [resd_pkg::POS_W-1:0] delta;

    always_comb
    begin
        delta          = pos - cur.pos;
        step           = '0;
        step.entry     = cur;
        step.entry.pos = pos;
        if (in_range && (delta != '0))
        begin
            step.wr = 1'b1;
            case (delta)
                resd_pkg::DELTA_RIGHT:
                begin
                    if (cur.right_cnt < lim_right)
                    begin
                        step.entry.right_cnt = cur.right_cnt + 1'b1;
                    end
                    else
                    begin
                        step.entry.right_cnt = '0;
                        step.fire            = 1'b1;
                        step.right           = 1'b1;
                    end
                end
                resd_pkg::DELTA_LEFT:
                begin
                    if (cur.left_cnt < lim_left)
                    begin
                        step.entry.left_cnt = cur.left_cnt + 1'b1;
                    end
                    else
                    begin
                        step.entry.left_cnt = '0;
                        step.fire           = 1'b1;
                    end
                end
                default:
                begin
                    // jump by two: position only
                    step.fire = 1'b0;
                end
            endcase
        end
    end

endmodule

/* design/rotary_encoder_step_decoder.sv */
// ----------------------------------------------------------------------------
// rotary encoder step decoder
// multi-channel quadrature decoder with per-direction skip counters
// ----------------------------------------------------------------------------
//  channel   dir   payload                        transfer when
//  samples   in    channel, clk_level, dt_level   valid && ready
//  actions   out   event_channel, turn_right      valid && ready
//  cfg       in    cfg_we, cfg_index, cfg_data    cfg_we
//
// one sample per cycle while samples are not stalled; an action follows its sample
// through the ram read, then the update into the output register
// per-channel state lives in a ram, back-to-back samples of one channel use a
// bypass of the last write; a valid bit per entry makes reset immediate
// samples stall only while an action waits in the output register
// ----------------------------------------------------------------------------
`include "rotary_encoder_step_decoder_defines.svh"

module rotary_encoder_step_decoder #(
    parameter int CHANNELS = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    resd_in_if.sink                         samples,
    resd_out_if.source                      actions,
    input  logic                            cfg_we,
    input  logic [resd_pkg::IDX_W-1:0]      cfg_index,
    input  logic [resd_pkg::DATA_W-1:0]     cfg_data
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [resd_pkg::CH_W:0] NUM_CH = (resd_pkg::CH_W + 1)'(CHANNELS);

    // configuration
    logic [resd_pkg::DATA_W-1:0] skip_left_reg,  skip_left_next;
    logic [resd_pkg::DATA_W-1:0] skip_right_reg, skip_right_next;

    // update stage
    logic                         s1_valid_reg, s1_valid_next;
    logic [resd_pkg::CH_W-1:0]    s1_ch_reg,    s1_ch_next;
    logic [resd_pkg::POS_W-1:0]   s1_pos_reg,   s1_pos_next;
    logic                         s1_inr_reg,   s1_inr_next;
    logic [AW-1:0]                s1_addr_reg,  s1_addr_next;

    // bypass of the last write
    logic                         fwd_valid_reg, fwd_valid_next;
    logic [AW-1:0]                fwd_addr_reg,  fwd_addr_next;
    resd_pkg::entry_t             fwd_data_reg,  fwd_data_next;

    logic [CHANNELS-1:0]          vld_reg, vld_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [resd_pkg::CH_W-1:0]    out_ch_reg,    out_ch_next;
    logic                         out_right_reg, out_right_next;

    logic                         in_xfer;
    logic                         in_range;
    logic [AW-1:0]                in_addr;
    logic                         out_free;
    logic                         s1_go;
    logic [resd_pkg::ENTRY_W-1:0] ram_rdata;
    resd_pkg::entry_t             cur;
    resd_pkg::step_t              step;
    logic                         do_wr;
    logic [resd_pkg::CNT_W-1:0]   lim_left;
    logic [resd_pkg::CNT_W-1:0]   lim_right;

    assign out_free       = !out_valid_reg || actions.ready;
    assign s1_go          = !s1_valid_reg || out_free;
    assign samples.ready  = s1_go;
    assign in_xfer        = samples.valid && s1_go;
    assign in_range       = {1'b0, samples.channel} < NUM_CH;
    assign in_addr        = in_range ? samples.channel[AW-1:0] : '0;
    assign do_wr          = s1_valid_reg && s1_go && step.wr;

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            cur = fwd_data_reg;
        end
        else if (vld_reg[s1_addr_reg])
        begin
            cur = resd_pkg::entry_t'(ram_rdata);
        end
        else
        begin
            cur = '0;
        end
    end

    assign lim_left  = skip_left_reg[{s1_ch_reg, 3'b000} +: resd_pkg::CNT_W];
    assign lim_right = skip_right_reg[{s1_ch_reg, 3'b000} +: resd_pkg::CNT_W];

    resd_ram #(
        .WIDTH (resd_pkg::ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (do_wr),
        .waddr (s1_addr_reg),
        .wdata (step.entry),
        .re    (in_xfer),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    resd_step u_step (
        .in_range  (s1_inr_reg),
        .pos       (s1_pos_reg),
        .cur       (cur),
        .lim_left  (lim_left),
        .lim_right (lim_right),
        .step      (step)
    );

    always_comb
    begin
        skip_left_next  = skip_left_reg;
        skip_right_next = skip_right_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                resd_pkg::REG_SKIP_LEFT:  skip_left_next  = cfg_data;
                resd_pkg::REG_SKIP_RIGHT: skip_right_next = cfg_data;
                default:                  skip_left_next  = skip_left_reg;
            endcase
        end

        s1_valid_next  = s1_valid_reg;
        s1_ch_next     = s1_ch_reg;
        s1_pos_next    = s1_pos_reg;
        s1_inr_next    = s1_inr_reg;
        s1_addr_next   = s1_addr_reg;
        fwd_valid_next = fwd_valid_reg;
        fwd_addr_next  = fwd_addr_reg;
        fwd_data_next  = fwd_data_reg;
        vld_next       = vld_reg;
        if (s1_go)
        begin
            s1_valid_next  = samples.valid;
            s1_ch_next     = samples.channel;
            s1_pos_next    = {samples.clk_level, samples.clk_level ^ samples.dt_level};
            s1_inr_next    = in_range;
            s1_addr_next   = in_addr;
            // covers the read issued at the same edge as this write
            fwd_valid_next = do_wr;
            fwd_addr_next  = s1_addr_reg;
            fwd_data_next  = step.entry;
        end
        if (do_wr)
        begin
            vld_next[s1_addr_reg] = 1'b1;
        end

        out_valid_next = out_valid_reg;
        out_ch_next    = out_ch_reg;
        out_right_next = out_right_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg && step.fire;
            out_ch_next    = s1_ch_reg;
            out_right_next = step.right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_left_reg  <= '0;
            skip_right_reg <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            skip_left_reg  <= skip_left_next;
            skip_right_reg <= skip_right_next;
            s1_valid_reg   <= s1_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            vld_reg        <= vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ch_reg      <= s1_ch_next;
        s1_pos_reg     <= s1_pos_next;
        s1_inr_reg     <= s1_inr_next;
        s1_addr_reg    <= s1_addr_next;
        fwd_addr_reg   <= fwd_addr_next;
        fwd_data_reg   <= fwd_data_next;
        out_ch_reg     <= out_ch_next;
        out_right_reg  <= out_right_next;
    end

    assign actions.valid         = out_valid_reg;
    assign actions.event_channel = out_ch_reg;
    assign actions.turn_right    = out_right_reg;

    `RESD_ASSERT_IMP(a_fire_writes, s1_valid_reg && step.fire, step.wr)
    `RESD_ASSERT_NXT(a_s1_holds, s1_valid_reg && !s1_go, s1_valid_reg && $stable(s1_ch_reg))
    `RESD_ASSERT_IMP(a_stall_blocks, s1_valid_reg && out_valid_reg && !actions.ready, !samples.ready)

endmodule
